@@ src/cvr_pkg.sv @@
package cvr_pkg;

  localparam int MAX_TAPS_DEFAULT = 4096;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WET_LEVEL = 2'd1;

  localparam logic [12:0] TAP_COUNT_RESET = 13'd1;
  localparam logic [15:0] Q15_ONE         = 16'd32768;

  localparam logic signed [15:0] GAIN_CLAMP_HIGH = 16'sd32440;
  localparam logic signed [15:0] GAIN_CLAMP_LOW  = 16'sh8000;
  localparam logic signed [16:0] GAIN_POS_LIMIT  = 17'sd32768;
  localparam logic signed [16:0] GAIN_NEG_LIMIT  = -17'sd32768;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // One decoded input word as it waits between the front and the engine.
  typedef struct packed {
    op_t                op;
    logic               tap_ok;
    logic [11:0]        tap_index;
    logic signed [15:0] value;
  } item_t;

  // Doubles a Q1.15 sample; results at or above 1.0 become 0.99, those below -1.0 become -1.0.
  function automatic logic signed [15:0] apply_gain(input logic signed [15:0] x);
    logic signed [16:0] g;
    g = $signed({x, 1'b0});
    if (g >= GAIN_POS_LIMIT) begin
      return GAIN_CLAMP_HIGH;
    end else if (g < GAIN_NEG_LIMIT) begin
      return GAIN_CLAMP_LOW;
    end else begin
      return g[15:0];
    end
  endfunction

endpackage

@@ src/convolution_reverb_fir.sv @@
// Channel   Direction  Handshake          Payload
// input     in         push / full        operation, tap_index, value
// result    out        empty / pop        out_sample
// config    in         cfg_write          cfg_index, cfg_data
//
// A tap load waits in the input queue and is stored when the idle engine takes it.
// A sample runs the tap loop over min(tap_count, samples since reset) taps, one
// multiply-accumulate per cycle over the coefficient and history memories, followed
// by a six-step mix and rounding sequence.
// Reset needs no clearing pass; a fill count stands in for the zeroed history.
// Two-word queues on both sides let the input and result sides stall on their own.
module convolution_reverb_fir #(
  parameter int MAX_TAPS = cvr_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              operation,
  input  logic [11:0]                       tap_index,
  input  logic signed [15:0]                value,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [15:0]                out_sample,
  input  logic                              cfg_write,
  input  logic [cvr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cvr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cvr_pkg::*;

  item_t              item;
  logic               item_valid;
  logic               item_take;
  logic               result_push;
  logic signed [15:0] result_data;
  logic               oq_full;

  cvr_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .tap_index  (tap_index),
    .value      (value),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  cvr_back #(
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_push (result_push),
    .result_data (result_data),
    .oq_full     (oq_full)
  );

  cvr_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (result_push),
    .wr_data    (result_data),
    .q_full     (oq_full),
    .empty      (empty),
    .pop        (pop),
    .out_sample (out_sample)
  );

endmodule

@@ src/cvr_front.sv @@
module cvr_front #(
  parameter int MAX_TAPS = cvr_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                operation,
  input  logic [11:0]         tap_index,
  input  logic signed [15:0]  value,
  output cvr_pkg::item_t      item,
  output logic                item_valid,
  input  logic                item_take
);
  import cvr_pkg::*;

  item_t      slot [2];
  item_t      cls;
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       accept;
  logic       take;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];
  assign accept     = push && !full;
  assign take       = item_take && item_valid;

  // Samples are gained here so the engine only has to store them.
  always_comb begin
    cls.op        = op_t'(operation);
    cls.tap_ok    = (32'(tap_index) < MAX_TAPS);
    cls.tap_index = tap_index;
    cls.value     = (op_t'(operation) == OP_SAMPLE) ? apply_gain(value) : value;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({accept, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/cvr_outq.sv @@
module cvr_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic signed [15:0] wr_data,
  output logic               q_full,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_sample
);

  logic signed [15:0] slot [2];
  logic               rd_ptr;
  logic               wr_ptr;
  logic [1:0]         count;
  logic               accept;
  logic               take;

  assign q_full     = (count == 2'd2);
  assign empty      = (count == 2'd0);
  assign out_sample = slot[rd_ptr];
  assign accept     = wr_en && !q_full;
  assign take       = pop && !empty;

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({accept, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/cvr_back.sv @@
module cvr_back #(
  parameter int MAX_TAPS = cvr_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cvr_pkg::item_t                      item,
  input  logic                                item_valid,
  output logic                                item_take,
  input  logic                                cfg_write,
  input  logic [cvr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cvr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                result_push,
  output logic signed [15:0]                  result_data,
  input  logic                                oq_full
);
  import cvr_pkg::*;

  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW     = $clog2(MAX_TAPS + 1);
  localparam int ACC_W  = 32 + CW;
  localparam int LO_W   = 24;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int MIX_W  = ACC_W + 18;
  localparam int Q_W    = MIX_W - 30;

  localparam logic [AW-1:0] LAST    = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TAPS);
  localparam logic signed [MIX_W-1:0] ROUND_HALF = {{(MIX_W-30){1'b0}}, 1'b1, 29'd0};
  localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'(32767);
  localparam logic signed [Q_W-1:0]   Q_MIN      = Q_W'(-32768);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_MAC     = 8'b0000_0010,
    S_MIX_LO  = 8'b0000_0100,
    S_MIX_HI  = 8'b0000_1000,
    S_MIX_DRY = 8'b0001_0000,
    S_SUM_A   = 8'b0010_0000,
    S_SUM_B   = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_t;

  state_t state;

  logic [12:0] tap_count;
  logic [15:0] wet_level;

  logic signed [15:0] coef_mem [MAX_TAPS];
  logic signed [15:0] hist_mem [MAX_TAPS];
  logic signed [15:0] coef_rd;
  logic signed [15:0] hist_rd;

  logic [AW-1:0] hist_ptr;
  logic [CW-1:0] fill;
  logic [AW-1:0] k;
  logic [AW-1:0] pos;
  logic [CW-1:0] left;
  logic          rd_valid;
  logic          prod_valid;

  logic signed [31:0]        prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [15:0]        gained;
  logic signed [41:0]        p_lo;
  logic signed [HI_W+16:0]   p_hi;
  logic signed [32:0]        p_dry;
  logic signed [MIX_W-1:0]   sum_a;
  logic signed [MIX_W-1:0]   sum_b;

  logic                      start;
  logic [CW-1:0]             taps_sat;
  logic [CW-1:0]             fill_inc;
  logic [CW-1:0]             eff;
  logic [15:0]               wet_sat;
  logic [15:0]               dry_w;
  logic signed [Q_W-1:0]     q;

  assign item_take = (state == S_IDLE);
  assign start     = (state == S_IDLE) && item_valid;

  // History slots never written since reset count as zero, so the tap loop is
  // cut at the number of samples seen so far.
  always_comb begin
    taps_sat = (32'(tap_count) > MAX_TAPS) ? MAX_CNT : CW'(tap_count);
    fill_inc = (fill == MAX_CNT) ? fill : fill + CW'(1);
    eff      = (taps_sat < fill_inc) ? taps_sat : fill_inc;
    wet_sat  = (wet_level > Q15_ONE) ? Q15_ONE : wet_level;
    dry_w    = Q15_ONE - wet_sat;
  end

  always_comb begin
    q = sum_b[MIX_W-1:30];
    if (q > Q_MAX) begin
      result_data = 16'sh7fff;
    end else if (q < Q_MIN) begin
      result_data = 16'sh8000;
    end else begin
      result_data = q[15:0];
    end
  end

  assign result_push = (state == S_OUT) && !oq_full;

  always_ff @(posedge clk) begin
    if (start && item.op == OP_LOAD && item.tap_ok) begin
      coef_mem[AW'(item.tap_index)] <= item.value;
    end
    coef_rd <= coef_mem[k];
  end

  always_ff @(posedge clk) begin
    if (start && item.op == OP_SAMPLE) begin
      hist_mem[hist_ptr] <= item.value;
    end
    hist_rd <= hist_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
      wet_level <= Q15_ONE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TAP_COUNT: tap_count <= cfg_data[12:0];
        REG_WET_LEVEL: wet_level <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hist_ptr   <= '0;
      fill       <= '0;
      left       <= '0;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= (state == S_MAC) && (left != '0);
      prod_valid <= rd_valid;
      unique case (state)
        S_IDLE: begin
          if (start && item.op == OP_SAMPLE) begin
            left     <= eff;
            hist_ptr <= (hist_ptr == LAST) ? '0 : hist_ptr + AW'(1);
            fill     <= fill_inc;
            state    <= S_MAC;
          end
        end
        S_MAC: begin
          if (left != '0) begin
            left <= left - CW'(1);
          end else if (!rd_valid && !prod_valid) begin
            state <= S_MIX_LO;
          end
        end
        S_MIX_LO:  state <= S_MIX_HI;
        S_MIX_HI:  state <= S_MIX_DRY;
        S_MIX_DRY: state <= S_SUM_A;
        S_SUM_A:   state <= S_SUM_B;
        S_SUM_B:   state <= S_OUT;
        S_OUT: begin
          if (!oq_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: tap loop, then the wide wet product taken in two halves and the dry product.
  always_ff @(posedge clk) begin
    if (start) begin
      k      <= '0;
      pos    <= hist_ptr;
      acc    <= '0;
      gained <= item.value;
    end
    if (state == S_MAC && left != '0) begin
      k   <= k + AW'(1);
      pos <= (pos == '0) ? LAST : pos - AW'(1);
    end
    if (rd_valid) begin
      prod <= coef_rd * hist_rd;
    end
    if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == S_MIX_LO) begin
      p_lo <= $signed({1'b0, wet_sat}) * $signed({1'b0, acc[LO_W-1:0]});
    end
    if (state == S_MIX_HI) begin
      p_hi <= $signed({1'b0, wet_sat}) * $signed(acc[ACC_W-1:LO_W]);
    end
    if (state == S_MIX_DRY) begin
      p_dry <= $signed({1'b0, dry_w}) * gained;
    end
    if (state == S_SUM_A) begin
      sum_a <= (MIX_W'(p_hi) <<< LO_W) + MIX_W'(p_lo);
    end
    if (state == S_SUM_B) begin
      sum_b <= sum_a + (MIX_W'(p_dry) <<< 15) + ROUND_HALF;
    end
  end

endmodule

@@ test/tb_convolution_reverb_fir.sv @@
module tb_convolution_reverb_fir;
  timeunit 1ns;
  timeprecision 1ps;

  import cvr_pkg::*;

  localparam int TAP_DEPTH = MAX_TAPS_DEFAULT;
  localparam int TAPS_WRITTEN = 16;
  localparam int UNITY = 32768;
  localparam int GAIN_CEILING = 32440;
  localparam longint ROUND_HALF = longint'(1) << 29;
  localparam int LOAD_SETTLE = 8;
  localparam int STALL_LIMIT = 25000;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic operation;
  logic [11:0] tap_index;
  logic signed [15:0] value;
  logic empty;
  logic pop;
  logic signed [15:0] out_sample;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Mirror of the block's state and registers.
  logic signed [15:0] coeffs [TAP_DEPTH];
  logic signed [15:0] history [TAP_DEPTH] = '{default: '0};
  int unsigned hist_ptr = 0;
  int unsigned taps_in_use = 1;
  int unsigned wet_mix = UNITY;

  logic signed [15:0] expected_out [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_hold = 0;
  bit idling = 1'b1;

  convolution_reverb_fir u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .tap_index (tap_index),
    .value     (value),
    .empty     (empty),
    .pop       (pop),
    .out_sample(out_sample),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Pushes one sample through the gain, delay line, convolution and mix.
  function automatic logic signed [15:0] reverb_sample(input logic signed [15:0] x);
    int g;
    int unsigned taps;
    int unsigned w;
    int unsigned pos;
    int unsigned k;
    longint acc;
    longint mix;
    longint r;
    g = 2 * int'(x);
    if (g >= UNITY) g = GAIN_CEILING;
    if (g < -UNITY) g = -UNITY;
    history[hist_ptr] = 16'(g);
    taps = (taps_in_use > TAP_DEPTH) ? TAP_DEPTH : taps_in_use;
    acc = 0;
    pos = hist_ptr;
    for (k = 0; k < taps; k++) begin
      acc += longint'(coeffs[k]) * longint'(history[pos]);
      pos = (pos == 0) ? TAP_DEPTH - 1 : pos - 1;
    end
    hist_ptr = (hist_ptr + 1 >= TAP_DEPTH) ? 0 : hist_ptr + 1;
    w = (wet_mix > UNITY) ? UNITY : wet_mix;
    mix = longint'(w) * acc + longint'(UNITY - w) * longint'(g) * longint'(UNITY);
    r = (mix + ROUND_HALF) >>> 30;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly random, with the corners of the gain clamp mixed in.
  function automatic logic signed [15:0] pick_value();
    if ($urandom_range(0, 3) != 0) return 16'($urandom());
    case ($urandom_range(0, 8))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return -16'sd1;
      5: return 16'sd16384;
      6: return 16'sd16383;
      7: return -16'sd16384;
      default: return -16'sd16385;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      if (operation == OP_SAMPLE) begin
        expected_out.push_back(reverb_sample(value));
      end else begin
        coeffs[tap_index] = value;
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic signed [15:0] want;
    if (!rst && pop && !empty) begin
      if (expected_out.size() == 0) begin
        $error("out_sample: no word expected, got %0d", out_sample);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if (out_sample !== want) begin
          $error("out_sample: expected %0d, got %0d", want, out_sample);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side. A long hold requested by a test is counted down here.
  initial begin : result_taker
    int unsigned stall;
    pop <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        stall = idling ? gap_length() : 0;
        pop <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Leaves push high when no gap follows, so back-to-back words need no
  // lowering in between.
  task automatic send_word(input op_t op, input logic [11:0] idx,
                           input logic signed [15:0] val);
    int unsigned gap;
    push <= 1'b1;
    operation <= op;
    tap_index <= idx;
    value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = idling ? gap_length() : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_tap(input logic [11:0] idx, input logic signed [15:0] val);
    send_word(OP_LOAD, idx, val);
  endtask

  task automatic play(input logic signed [15:0] val);
    send_word(OP_SAMPLE, 12'd0, val);
  endtask

  // Lowering push lets the last accepted word reach the predictor.
  // A load gives no result, so a settling wait lets the last one land.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_TAP_COUNT) begin
      taps_in_use = data[12:0];
    end else if (idx == REG_WET_LEVEL) begin
      wet_mix = data;
    end
  endtask

  // The low taps get written once, and tap_count never goes above that span.
  task automatic test_tap_fill();
    int unsigned k;
    for (k = 0; k < TAPS_WRITTEN; k++) begin
      case (k)
        0: load_tap(12'(k), 16'sd32767);
        1: load_tap(12'(k), -16'sd32768);
        2: load_tap(12'(k), 16'sd0);
        3: load_tap(12'(k), 16'sd1);
        4: load_tap(12'(k), -16'sd1);
        default: load_tap(12'(k), 16'($urandom()));
      endcase
    end
  endtask

  task automatic test_gain_clamp();
    play(16'sd32767);
    play(16'sd16384);
    play(16'sd16383);
    play(-16'sd16384);
    play(-16'sd16385);
    play(-16'sd32768);
    play(16'sd0);
    play(16'sd1);
    play(-16'sd1);
  endtask

  task automatic test_mix_extremes();
    write_register(REG_TAP_COUNT, 16'd4);
    write_register(REG_WET_LEVEL, 16'd0);
    play(16'sd32767);
    play(-16'sd32768);
    write_register(REG_WET_LEVEL, 16'hFFFF);
    play(16'sd12345);
    play(-16'sd32768);
    write_register(REG_WET_LEVEL, 16'd16384);
    play(16'sd20000);
    play(-16'sd9999);
    write_register(REG_TAP_COUNT, 16'd0);
    play(16'sd32767);
    play(-16'sd1);
    // Writes to unused indexes must leave both registers alone.
    write_register(REG_SPARE_A, 16'hFFFF);
    write_register(REG_SPARE_B, 16'hFFFF);
    play(16'sd777);
    write_register(REG_TAP_COUNT, 16'(TAPS_WRITTEN));
    play(-16'sd20000);
    write_register(REG_TAP_COUNT, 16'(TAPS_WRITTEN - 1));
    play(16'sd30000);
  endtask

  // A back-to-back run with every written tap in use.
  task automatic test_history_run();
    write_register(REG_TAP_COUNT, 16'(TAPS_WRITTEN));
    write_register(REG_WET_LEVEL, 16'd32768);
    idling = 1'b0;
    repeat (20) play(pick_value());
    idling = 1'b1;
  endtask

  task automatic test_random_mix();
    int unsigned phase;
    int unsigned k;
    int unsigned roll;
    for (phase = 0; phase < 4; phase++) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) write_register(REG_TAP_COUNT, 16'd0);
      else if (roll == 1) write_register(REG_TAP_COUNT, 16'(TAPS_WRITTEN));
      else write_register(REG_TAP_COUNT, 16'($urandom_range(1, TAPS_WRITTEN)));
      roll = $urandom_range(0, 9);
      if (roll == 0) write_register(REG_WET_LEVEL, 16'd0);
      else if (roll == 1) write_register(REG_WET_LEVEL, 16'd32768);
      else if (roll == 2) write_register(REG_WET_LEVEL, 16'($urandom_range(32769, 65535)));
      else write_register(REG_WET_LEVEL, 16'($urandom_range(0, 32768)));
      for (k = 0; k < 12; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          load_tap(12'($urandom_range(0, 4095)), 16'($urandom()));
        end else begin
          play(pick_value());
        end
      end
    end
  endtask

  // The result side holds off long enough for both queues to fill.
  task automatic test_backpressure();
    write_register(REG_TAP_COUNT, 16'd2);
    write_register(REG_WET_LEVEL, 16'd20000);
    rx_hold = 400;
    repeat (16) play(pick_value());
  endtask

  // The sender waits for every result, then sends a burst with no gaps.
  task automatic test_pause_and_burst();
    wait_idle();
    idling = 1'b0;
    repeat (20) play(pick_value());
    idling = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    operation <= OP_LOAD;
    tap_index <= '0;
    value <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_tap_fill();
    test_gain_clamp();
    test_mix_extremes();
    test_history_run();
    test_random_mix();
    test_backpressure();
    test_pause_and_burst();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
